FILE: sv/yxy_pkg.sv
// Package: widths, payload and config types, matrix coefficients.
`timescale 1ns / 1ps
`default_nettype none
package yxy_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LUM_W     = 24;
    localparam int CH_W      = 16;
    localparam int LMAX_W    = 23;
    localparam int L_INT     = 2;
    localparam int L_W       = FRAC_BITS + L_INT;
    localparam int S_W       = CH_W + 2;
    localparam int SMAG_W    = CH_W + 1;
    localparam int P_W       = L_W + SMAG_W;
    localparam int COEF_W    = FRAC_BITS + 2;
    localparam int SPLIT     = SMAG_W;
    localparam int HI_W      = P_W - SPLIT;
    localparam int PHI_W     = HI_W + COEF_W;
    localparam int PLO_W     = SPLIT + COEF_W;
    localparam int FULL_W    = P_W + COEF_W;
    localparam int TERM_W    = FULL_W - FRAC_BITS + 1;
    localparam int SUM_W     = TERM_W + 2;
    localparam int CL_W      = FRAC_BITS + 1;
    localparam int FLO_UP    = (FRAC_BITS >= CH_W) ? FRAC_BITS - CH_W : 0;
    localparam int FLO_DN    = (FRAC_BITS >= CH_W) ? 0 : CH_W - FRAC_BITS;
    localparam int CFG_A_W   = 3;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_LUM_MAX   = 3'd0,
        CFG_LUM_FLOOR = 3'd1,
        CFG_X_CAP     = 3'd2,
        CFG_Y_CAP     = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [LUM_W-1:0] lum_in;
        logic [CH_W-1:0]         chroma_x;
        logic [CH_W-1:0]         chroma_y;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fault;
    } t_out_item;

    typedef struct packed {
        logic [LMAX_W-1:0] lum_max;
        logic [CH_W-1:0]   lum_floor;
        logic [CH_W-1:0]   x_cap;
        logic [CH_W-1:0]   y_cap;
    } t_cfg;

    typedef struct packed {
        logic            valid;
        logic [L_W-1:0]  l;
        logic [CH_W-1:0] cx;
        logic [CH_W-1:0] cy;
    } t_lum_out;

    typedef struct packed {
        logic           valid;
        logic           fault;
        logic [L_W-1:0] l;
        logic [P_W-1:0] qx;
        logic [P_W-1:0] qz;
        logic           zneg;
    } t_xyz;

    // Q.24 magnitude rounded half up to Q.FRAC_BITS
    function automatic logic [COEF_W-1:0] coef_at(input longint unsigned m);
        longint unsigned half;
        half = (64'd1 << (24 - FRAC_BITS)) >> 1;
        return COEF_W'((m + half) >> (24 - FRAC_BITS));
    endfunction

    localparam logic [COEF_W-1:0] COEF_MAG [9] = '{
        coef_at(54366216), coef_at(25789098), coef_at(8363945),
        coef_at(16261417), coef_at(31473906), coef_at(697194),
        coef_at(933619),   coef_at(3423273),  coef_at(17738735)
    };
    localparam logic COEF_NEG [9] = '{
        1'b0, 1'b1, 1'b1,
        1'b1, 1'b0, 1'b0,
        1'b0, 1'b1, 1'b0
    };

endpackage
`default_nettype wire

FILE: sv/yxy_lum_norm.sv
// Chroma capping and pipelined luminance normalization (one quotient bit per stage).
`timescale 1ns / 1ps
`default_nettype none
module yxy_lum_norm import yxy_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output t_lum_out      o_stage
);
    localparam int N = L_W;

    logic              r_v   [0:N];
    logic [LMAX_W-1:0] r_rem [0:N];
    logic [L_W-1:0]    r_q   [0:N];
    logic [L_W-1:0]    r_dl  [0:N];
    logic [CH_W-1:0]   r_cx  [0:N];
    logic [CH_W-1:0]   r_cy  [0:N];
    logic              r_pos [0:N];
    logic              r_sat [0:N];

    logic [LMAX_W-1:0] mag;
    assign mag = i_item.lum_in[LMAX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_cx[0]  <= (i_item.chroma_x > i_cfg.x_cap) ? i_cfg.x_cap : i_item.chroma_x;
            r_cy[0]  <= (i_item.chroma_y > i_cfg.y_cap) ? i_cfg.y_cap : i_item.chroma_y;
            r_pos[0] <= !i_item.lum_in[LUM_W-1] && (|mag);
            // quotient would exceed Q2.F: lum >= lum_max * 2^L_INT
            r_sat[0] <= (i_cfg.lum_max == '0) ||
                        ({{L_INT{1'b0}}, mag} >= {i_cfg.lum_max, {L_INT{1'b0}}});
            r_rem[0] <= mag >> L_INT;
            r_dl[0]  <= {mag[L_INT-1:0], {FRAC_BITS{1'b0}}};
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_div
        logic [LMAX_W:0] t;
        logic            ge;
        logic [LMAX_W:0] diff;
        assign t    = {r_rem[k], r_dl[k][L_W-1]};
        assign ge   = t >= {1'b0, i_cfg.lum_max};
        assign diff = t - {1'b0, i_cfg.lum_max};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rem[k+1] <= ge ? diff[LMAX_W-1:0] : t[LMAX_W-1:0];
                r_q[k+1]   <= {r_q[k][L_W-2:0], ge};
                r_dl[k+1]  <= {r_dl[k][L_W-2:0], 1'b0};
                r_cx[k+1]  <= r_cx[k];
                r_cy[k+1]  <= r_cy[k];
                r_pos[k+1] <= r_pos[k];
                r_sat[k+1] <= r_sat[k];
            end
        end
    end

    logic [L_W-1:0] flo;
    logic [L_W-1:0] qs;
    assign flo = (L_W'(i_cfg.lum_floor) << FLO_UP) >> FLO_DN;
    assign qs  = r_sat[N] ? {L_W{1'b1}} : r_q[N];

    always_comb begin
        o_stage.valid = r_v[N];
        o_stage.cx    = r_cx[N];
        o_stage.cy    = r_cy[N];
        if (!r_pos[N]) begin
            o_stage.l = '0;
        end else begin
            o_stage.l = (qs > flo) ? qs : flo;
        end
    end
endmodule
`default_nettype wire

FILE: sv/yxy_xyz_div.sv
// Yxy to XYZ: products L*x and L*(1-x-y), two pipelined divisions by y.
`timescale 1ns / 1ps
`default_nettype none
module yxy_xyz_div import yxy_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire t_lum_out i_stage,
    output t_xyz          o_xyz
);
    localparam int N = P_W;

    logic            r_av;
    logic [L_W-1:0]  r_al;
    logic [CH_W-1:0] r_acx;
    logic [CH_W-1:0] r_acy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (i_en) begin
            r_av <= i_stage.valid;
        end
        if (i_en) begin
            r_al  <= i_stage.l;
            r_acx <= i_stage.cx;
            r_acy <= i_stage.cy;
        end
    end

    // 1 - x - y with 1 = 65536
    logic [S_W-1:0]    s;
    logic [SMAG_W-1:0] smag;
    assign s    = {2'b01, {CH_W{1'b0}}} - S_W'(r_acx) - S_W'(r_acy);
    assign smag = s[S_W-1] ? SMAG_W'(-s) : s[SMAG_W-1:0];

    logic            r_v     [0:N];
    logic [CH_W-1:0] r_remx  [0:N];
    logic [CH_W-1:0] r_remz  [0:N];
    logic [P_W-1:0]  r_dx    [0:N];
    logic [P_W-1:0]  r_dz    [0:N];
    logic [P_W-1:0]  r_qx    [0:N];
    logic [P_W-1:0]  r_qz    [0:N];
    logic            r_zneg  [0:N];
    logic            r_fault [0:N];
    logic [L_W-1:0]  r_l     [0:N];
    logic [CH_W-1:0] r_cy    [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r_av;
        end
        if (i_en) begin
            r_dx[0]    <= P_W'(r_al * r_acx);
            r_dz[0]    <= P_W'(r_al * smag);
            r_zneg[0]  <= s[S_W-1];
            r_remx[0]  <= '0;
            r_remz[0]  <= '0;
            r_qx[0]    <= '0;
            r_qz[0]    <= '0;
            r_fault[0] <= (r_acy == '0);
            r_l[0]     <= r_al;
            r_cy[0]    <= r_acy;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_div
        logic [CH_W:0] tx, tz, dfx, dfz;
        logic          gx, gz;
        assign tx  = {r_remx[k], r_dx[k][P_W-1]};
        assign tz  = {r_remz[k], r_dz[k][P_W-1]};
        assign gx  = tx >= {1'b0, r_cy[k]};
        assign gz  = tz >= {1'b0, r_cy[k]};
        assign dfx = tx - {1'b0, r_cy[k]};
        assign dfz = tz - {1'b0, r_cy[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_remx[k+1]  <= gx ? dfx[CH_W-1:0] : tx[CH_W-1:0];
                r_remz[k+1]  <= gz ? dfz[CH_W-1:0] : tz[CH_W-1:0];
                r_qx[k+1]    <= {r_qx[k][P_W-2:0], gx};
                r_qz[k+1]    <= {r_qz[k][P_W-2:0], gz};
                r_dx[k+1]    <= {r_dx[k][P_W-2:0], 1'b0};
                r_dz[k+1]    <= {r_dz[k][P_W-2:0], 1'b0};
                r_zneg[k+1]  <= r_zneg[k];
                r_fault[k+1] <= r_fault[k];
                r_l[k+1]     <= r_l[k];
                r_cy[k+1]    <= r_cy[k];
            end
        end
    end

    assign o_xyz.valid = r_v[N];
    assign o_xyz.fault = r_fault[N];
    assign o_xyz.l     = r_l[N];
    assign o_xyz.qx    = r_qx[N];
    assign o_xyz.qz    = r_qz[N];
    assign o_xyz.zneg  = r_zneg[N];
endmodule
`default_nettype wire

FILE: sv/yxy_matrix.sv
// sRGB matrix as split partial products, row sums, clamp, scale to 8 bits.
`timescale 1ns / 1ps
`default_nettype none
module yxy_matrix import yxy_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire t_xyz i_xyz,
    output logic      o_valid,
    output t_out_item o_item
);
    logic [P_W-1:0] vmag [3];
    logic           vneg [3];
    always_comb begin
        vmag[0] = i_xyz.qx;
        vmag[1] = P_W'(i_xyz.l);
        vmag[2] = i_xyz.qz;
        vneg[0] = 1'b0;
        vneg[1] = 1'b0;
        vneg[2] = i_xyz.zneg;
    end

    logic             r_1v, r_2v, r_3v, r_1f, r_2f, r_3f;
    logic [PHI_W-1:0] r_phi  [9];
    logic [PLO_W-1:0] r_plo  [9];
    logic             r_neg  [9];
    logic signed [TERM_W-1:0] r_term [9];
    logic [CL_W-1:0]  r_clip [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_1v    <= 1'b0;
            r_2v    <= 1'b0;
            r_3v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_1v    <= i_xyz.valid;
            r_2v    <= r_1v;
            r_3v    <= r_2v;
            o_valid <= r_3v;
        end
    end

    for (genvar j = 0; j < 9; j++) begin : g_term
        logic [FULL_W-1:0]     full;
        logic [TERM_W-2:0]     tmag;
        assign full = (FULL_W'(r_phi[j]) << SPLIT) + FULL_W'(r_plo[j]);
        assign tmag = full[FULL_W-1:FRAC_BITS];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_phi[j]  <= vmag[j%3][P_W-1:SPLIT] * COEF_MAG[j];
                r_plo[j]  <= vmag[j%3][SPLIT-1:0] * COEF_MAG[j];
                r_neg[j]  <= vneg[j%3] ^ COEF_NEG[j];
                r_term[j] <= r_neg[j] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_row
        logic signed [SUM_W-1:0] sum;
        logic [CL_W+7:0]         scaled;
        assign sum = SUM_W'(r_term[3*i]) + SUM_W'(r_term[3*i+1]) + SUM_W'(r_term[3*i+2]);
        assign scaled = ({r_clip[i], 8'b0}) - (CL_W+8)'(r_clip[i]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (sum < 0) begin
                    r_clip[i] <= '0;
                end else if (sum > $signed(SUM_W'(1) << FRAC_BITS)) begin
                    r_clip[i] <= CL_W'(1) << FRAC_BITS;
                end else begin
                    r_clip[i] <= sum[CL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_1f <= i_xyz.fault;
            r_2f <= r_1f;
            r_3f <= r_2f;
            o_item.fault <= r_3f;
            o_item.red   <= r_3f ? 8'd0 : g_row[0].scaled[FRAC_BITS+7:FRAC_BITS];
            o_item.green <= r_3f ? 8'd0 : g_row[1].scaled[FRAC_BITS+7:FRAC_BITS];
            o_item.blue  <= r_3f ? 8'd0 : g_row[2].scaled[FRAC_BITS+7:FRAC_BITS];
        end
    end
endmodule
`default_nettype wire

FILE: sv/yxy_texel_to_rgb_core.sv
// Top level: Yxy sky texel to 8-bit linear sRGB, config registers and pipeline.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-------------------------
//  input     | i_in_valid / o_in_ready     | i_in_item  (t_in_item)
//  output    | o_out_valid / i_out_ready   | o_out_item (t_out_item)
//  config    | i_cfg_we                    | i_cfg_addr, i_cfg_data
//
// One texel per cycle while the pipeline advances. A texel passes the luminance divider
// (one quotient bit per stage), then the two divisions by y, then the
// matrix, clamp and scale, the last of these being the output register.
// Reset clears only valid bits and loads the config defaults. The whole
// pipeline advances when the output register is empty or its transfer
// completes, else holds.
`timescale 1ns / 1ps
`default_nettype none
module yxy_texel_to_rgb_core import yxy_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_A_W-1:0] i_cfg_addr,
    input  wire logic [LMAX_W-1:0]  i_cfg_data
);
    t_cfg     r_cfg;
    t_lum_out lum;
    t_xyz     xyz;
    logic     en;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lum_max   <= LMAX_W'(65536);
            r_cfg.lum_floor <= CH_W'(58982);
            r_cfg.x_cap     <= CH_W'(32768);
            r_cfg.y_cap     <= CH_W'(22938);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LUM_MAX:   r_cfg.lum_max   <= i_cfg_data;
                CFG_LUM_FLOOR: r_cfg.lum_floor <= i_cfg_data[CH_W-1:0];
                CFG_X_CAP:     r_cfg.x_cap     <= i_cfg_data[CH_W-1:0];
                CFG_Y_CAP:     r_cfg.y_cap     <= i_cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    yxy_lum_norm u_lum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_cfg   (r_cfg),
        .o_stage (lum)
    );

    yxy_xyz_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stage (lum),
        .o_xyz   (xyz)
    );

    yxy_matrix u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_xyz   (xyz),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );
endmodule
`default_nettype wire

FILE: sv/yxy_checker.sv
// Port-level checker for the texel core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module yxy_checker import yxy_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire t_in_item           i_in_item,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire t_out_item          o_out_item
);
    // a result waiting for transfer stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("input changed while waiting for transfer");

    a_fault_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.fault |->
            o_out_item.red == 8'd0 && o_out_item.green == 8'd0 && o_out_item.blue == 8'd0)
        else $error("fault with nonzero channel");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("valid output after reset");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input stalled without output backpressure");
endmodule

bind yxy_texel_to_rgb_core yxy_checker u_chk (.*);
`default_nettype wire
